[rtl/wpd_pkg.sv]
// Package: shared types, codes and sample conversion for the WAV decoder.
package wpd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } wpd_in_t;

    typedef struct packed {
        logic signed [31:0] mono_sample;
        logic [31:0]        rate_hz;
        logic [3:0]         error_code;
        logic               is_status;
        logic               last_result;
    } wpd_out_t;

    // Work handed from the parser to the averaging back end.
    typedef struct packed {
        logic               frame_done;
        logic               is_status;
        logic signed [39:0] sum;
        logic [6:0]         divisor;
        logic [31:0]        rate;
        logic [3:0]         code;
    } wpd_job_t;

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_SIZE,
        PH_SKIP, PH_FMT, PH_DATA, PH_PAD, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_OUT} div_state_t;

    localparam logic [3:0] ERR_OK = 4'd0, ERR_NOT_RIFF = 4'd1, ERR_NOT_WAVE = 4'd2,
        ERR_FMT_SMALL = 4'd3, ERR_NO_DATA = 4'd4, ERR_NO_FMT = 4'd5,
        ERR_BAD_ALIGN = 4'd6, ERR_UNSUPPORTED = 4'd7, ERR_TOO_SMALL = 4'd8;

    localparam logic [31:0] TAG_RIFF = 32'h46464952, TAG_WAVE = 32'h45564157,
        TAG_FMT = 32'h20746d66, TAG_DATA = 32'h61746164;

    localparam logic [15:0] FMT_PCM = 16'd1, FMT_FLOAT = 16'd3;

    // Convert an IEEE float32 word to Q1.31 with saturation.
    function automatic logic [31:0] float_to_q31(input logic [31:0] w);
        logic [7:0]  e;
        logic [23:0] m;
        logic [31:0] mag;
        logic [31:0] r;
        e = w[30:23];
        m = {1'b1, w[22:0]};
        mag = '0;
        if (e == 8'hff) begin
            if (w[22:0] != '0) r = '0;
            else r = w[31] ? 32'h80000000 : 32'h7fffffff;
        end else if (e == 8'h00) begin
            r = '0;
        end else if (e >= 8'd127) begin
            r = w[31] ? 32'h80000000 : 32'h7fffffff;
        end else begin
            if (e >= 8'd119) mag = {8'd0, m} << (e - 8'd119);
            else if (e > 8'd87) mag = {8'd0, m} >> (8'd119 - e);
            else mag = '0;
            r = w[31] ? (32'd0 - mag) : mag;
        end
        return r;
    endfunction

endpackage

[rtl/wpd_front.sv]
// Front end: walks the RIFF chunks, captures fmt, assembles and sums samples.
module wpd_front import wpd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  wpd_in_t  in_item,
    output logic     job_valid,
    input  logic     job_ready,
    output wpd_job_t job
);

    phase_t             phase_reg, phase_next;
    logic [5:0]         pos_reg, pos_next;
    logic [31:0]        tag_reg, tag_next;
    logic [32:0]        rem_reg, rem_next;
    logic [15:0]        fmt_reg, fmt_next, chan_reg, chan_next, bps_reg, bps_next;
    logic [31:0]        rate_reg, rate_next, asm_reg, asm_next;
    logic [1:0]         idx_reg, idx_next;
    logic [15:0]        fci_reg, fci_next;
    logic signed [39:0] acc_reg, acc_next;
    logic [3:0]         err_reg, err_next;
    logic               sfmt_reg, sfmt_next, sdata_reg, sdata_next;
    logic               jv_reg, jv_next;
    wpd_job_t           job_reg, job_next;

    logic        fire;
    logic [7:0]  b;
    logic [31:0] sz, shifted, word, q;
    logic [31:0] low;
    logic [2:0]  nb;
    logic signed [39:0] dec, sum;
    logic        fdone;
    logic [3:0]  code;
    logic        fmt_ok;
    logic [4:0]  off;

    assign in_ready  = !jv_reg || job_ready;
    assign fire      = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF_TAG; pos_reg <= '0; tag_reg <= '0; rem_reg <= '0;
            fmt_reg <= '0; chan_reg <= '0; bps_reg <= '0; rate_reg <= '0;
            asm_reg <= '0; idx_reg <= '0; fci_reg <= '0; acc_reg <= '0;
            err_reg <= '0; sfmt_reg <= 1'b0; sdata_reg <= 1'b0; jv_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; pos_reg <= pos_next; tag_reg <= tag_next;
            rem_reg <= rem_next; fmt_reg <= fmt_next; chan_reg <= chan_next;
            bps_reg <= bps_next; rate_reg <= rate_next; asm_reg <= asm_next;
            idx_reg <= idx_next; fci_reg <= fci_next; acc_reg <= acc_next;
            err_reg <= err_next; sfmt_reg <= sfmt_next; sdata_reg <= sdata_next;
            jv_reg <= jv_next;
        end
        job_reg <= job_next;
    end

    always_comb begin
        phase_next = phase_reg; pos_next = pos_reg; tag_next = tag_reg;
        rem_next = rem_reg; fmt_next = fmt_reg; chan_next = chan_reg;
        bps_next = bps_reg; rate_next = rate_reg; asm_next = asm_reg;
        idx_next = idx_reg; fci_next = fci_reg; acc_next = acc_reg;
        err_next = err_reg; sfmt_next = sfmt_reg; sdata_next = sdata_reg;
        jv_next = jv_reg && !job_ready;
        job_next = job_reg;
        b = in_item.byte_in;
        fdone = 1'b0;
        shifted = {b, tag_reg[31:8]};
        sz = {b, rem_reg[23:0]};
        low = rem_reg[31:0] - 32'd1;
        nb = bps_reg[5:3];
        word = asm_reg | ({24'd0, b} << {idx_reg, 3'b000});
        q = float_to_q31(word);
        sum = acc_reg;
        dec = '0;
        code = ERR_OK;
        off = tag_reg[4:0];
        fmt_ok = (chan_reg <= 16'(MAX_CHANNELS)) &&
                 ((fmt_reg == FMT_FLOAT && bps_reg == 16'd32) ||
                  (fmt_reg == FMT_PCM && (bps_reg == 16'd8 || bps_reg == 16'd16 ||
                   bps_reg == 16'd24 || bps_reg == 16'd32)));
        if (fire) begin
            if (pos_reg < 6'd44) pos_next = pos_reg + 6'd1;
            case (phase_reg)
                PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
                    tag_next = shifted;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        if (phase_reg == PH_RIFF_TAG) begin
                            if (shifted != TAG_RIFF) begin
                                err_next = ERR_NOT_RIFF; phase_next = PH_HALT;
                            end else phase_next = PH_RIFF_SIZE;
                        end else if (phase_reg == PH_WAVE_TAG) begin
                            if (shifted != TAG_WAVE) begin
                                err_next = ERR_NOT_WAVE; phase_next = PH_HALT;
                            end else begin
                                phase_next = PH_CHUNK_ID; tag_next = '0;
                            end
                        end else begin
                            rem_next = '0; phase_next = PH_CHUNK_SIZE;
                        end
                    end
                end
                PH_RIFF_SIZE: begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        phase_next = PH_WAVE_TAG; tag_next = '0;
                    end
                end
                PH_CHUNK_SIZE: begin
                    rem_next = rem_reg | ({25'd0, b} << {idx_reg, 3'b000});
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        // Start the chunk body.
                        rem_next = {sz[0], sz};
                        idx_next = '0;
                        phase_next = PH_SKIP;
                        if (tag_reg == TAG_FMT) begin
                            if (sz < 32'd16) begin
                                err_next = ERR_FMT_SMALL; phase_next = PH_HALT;
                            end else begin
                                fmt_next = '0; chan_next = '0; bps_next = '0;
                                rate_next = '0; sfmt_next = 1'b1; tag_next = '0;
                                phase_next = PH_FMT;
                            end
                        end else if (tag_reg == TAG_DATA && !sdata_reg) begin
                            sdata_next = 1'b1;
                            if (!sfmt_reg || chan_reg == '0) begin
                                err_next = ERR_NO_FMT; phase_next = PH_HALT;
                            end else if (bps_reg < 16'd8) begin
                                err_next = ERR_BAD_ALIGN; phase_next = PH_HALT;
                            end else if (!fmt_ok) begin
                                err_next = ERR_UNSUPPORTED; phase_next = PH_HALT;
                            end else begin
                                asm_next = '0; fci_next = '0; acc_next = '0;
                                phase_next = PH_DATA;
                            end
                        end
                        if (sz == '0 && phase_next != PH_HALT) begin
                            phase_next = PH_CHUNK_ID; tag_next = '0;
                        end
                    end
                end
                PH_SKIP, PH_FMT, PH_DATA: begin
                    if (phase_reg == PH_FMT && tag_reg < 32'd16) begin
                        if (off < 5'd2) fmt_next = fmt_reg | (16'(b) << {off[0], 3'b000});
                        else if (off < 5'd4)
                            chan_next = chan_reg | (16'(b) << {off[0], 3'b000});
                        else if (off < 5'd8)
                            rate_next = rate_reg | (32'(b) << {off[1:0], 3'b000});
                        else if (off >= 5'd14)
                            bps_next = bps_reg | (16'(b) << {off[0], 3'b000});
                        tag_next = tag_reg + 32'd1;
                    end
                    if (phase_reg == PH_DATA) begin
                        asm_next = word;
                        if ({1'b0, idx_reg} + 3'd1 >= nb) begin
                            if (fmt_reg == FMT_FLOAT) dec = 40'(signed'(q));
                            else begin
                                case (bps_reg)
                                    16'd8: dec = 40'(signed'({word[7:0] ^ 8'h80, 24'd0}));
                                    16'd16: dec = 40'(signed'({word[15:0], 16'd0}));
                                    16'd24: dec = 40'(signed'({word[23:0], 8'd0}));
                                    default: dec = 40'(signed'(word));
                                endcase
                            end
                            sum = acc_reg + dec;
                            acc_next = sum;
                            asm_next = '0; idx_next = '0;
                            fci_next = fci_reg + 16'd1;
                            if (fci_reg + 16'd1 >= chan_reg) begin
                                acc_next = '0; fci_next = '0; fdone = 1'b1;
                            end
                        end else idx_next = idx_reg + 2'd1;
                    end
                    // Count down the body and step to pad or next header.
                    rem_next = {rem_reg[32], low};
                    if (low == '0) begin
                        if (rem_reg[32]) begin
                            phase_next = PH_PAD; rem_next = '0;
                        end else begin
                            phase_next = PH_CHUNK_ID; idx_next = '0; tag_next = '0;
                        end
                    end
                end
                PH_PAD: begin
                    phase_next = PH_CHUNK_ID; idx_next = '0; tag_next = '0;
                end
                default: ;
            endcase
            if (pos_reg + 6'd1 < 6'd44) code = ERR_TOO_SMALL;
            else if (err_next != ERR_OK) code = err_next;
            else if (!sdata_next) code = ERR_NO_DATA;
            // Queue a job for the back end.
            if (in_item.end_of_file || fdone) begin
                jv_next = 1'b1;
                job_next.frame_done = fdone && (!in_item.end_of_file || code == ERR_OK);
                job_next.is_status = in_item.end_of_file;
                job_next.sum = sum;
                job_next.divisor = chan_reg[6:0];
                job_next.rate = rate_next;
                job_next.code = in_item.end_of_file ? code : ERR_OK;
            end
            if (in_item.end_of_file) begin
                phase_next = PH_RIFF_TAG; pos_next = '0; tag_next = '0; rem_next = '0;
                fmt_next = '0; chan_next = '0; bps_next = '0; rate_next = '0;
                asm_next = '0; idx_next = '0; fci_next = '0; acc_next = '0;
                err_next = '0; sfmt_next = 1'b0; sdata_next = 1'b0;
            end
        end
    end

endmodule

[rtl/wpd_back.sv]
// Back end: divides a frame sum by the channel count, or passes a status job through, and registers the result.
module wpd_back import wpd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     job_valid,
    output logic     job_ready,
    input  wpd_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output wpd_out_t out_item
);

    div_state_t  state_reg, state_next;
    logic [39:0] quo_reg, quo_next;
    logic [6:0]  rmd_reg, rmd_next;
    logic [6:0]  den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    wpd_out_t    res_reg, res_next;
    logic [7:0]  trial;
    logic [39:0] mag;
    logic [39:0] qs;

    assign job_ready = (state_reg == DIV_IDLE);
    assign out_valid = (state_reg == DIV_OUT);
    assign out_item  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE; cnt_reg <= '0;
        end else begin
            state_reg <= state_next; cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next; rmd_reg <= rmd_next; den_reg <= den_next;
        neg_reg <= neg_next; res_reg <= res_next;
    end

    // Restoring division, one quotient bit per cycle on the magnitude.
    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg; quo_next = quo_reg;
        rmd_next = rmd_reg; den_next = den_reg; neg_next = neg_reg;
        res_next = res_reg;
        mag = job.sum[39] ? (40'd0 - job.sum) : job.sum;
        trial = {rmd_reg, quo_reg[39]};
        qs = '0;
        case (state_reg)
            DIV_IDLE: begin
                if (job_valid) begin
                    res_next.mono_sample = '0;
                    res_next.rate_hz = job.rate;
                    res_next.error_code = job.code;
                    res_next.is_status = job.is_status;
                    res_next.last_result = job.is_status;
                    quo_next = mag; rmd_next = '0; den_next = job.divisor;
                    neg_next = job.sum[39]; cnt_next = '0;
                    state_next = job.frame_done ? DIV_RUN : DIV_OUT;
                end
            end
            DIV_RUN: begin
                if (trial >= {1'b0, den_reg}) begin
                    rmd_next = 7'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[38:0], 1'b1};
                end else begin
                    rmd_next = trial[6:0];
                    quo_next = {quo_reg[38:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                // Apply the sign once the last quotient bit is in
                qs = neg_reg ? (40'd0 - quo_next) : quo_next;
                if (cnt_reg == 6'd39) begin
                    res_next.mono_sample = qs[31:0];
                    state_next = DIV_OUT;
                end
            end
            DIV_OUT: begin
                if (out_ready) state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

endmodule

[rtl/wav_pcm_stream_decoder.sv]
// WAV PCM stream decoder: 1 byte per cycle parse, serial-divider averaging per result.
// Bytes are accepted one per cycle until a queued job waits behind a busy back end.
// A frame-completing byte hands a job to the back end, whose serial divider finds
// the quotient bit by bit in DIV_RUN before DIV_OUT; a status without a frame goes
// straight to DIV_OUT. Sync active-low reset restarts at RIFF tag.
module wav_pcm_stream_decoder import wpd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wpd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wpd_out_t m_data
);

    logic     job_valid, job_ready;
    wpd_job_t job;

    wpd_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready), .in_item(s_data),
        .job_valid, .job_ready, .job
    );

    wpd_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .out_valid(m_valid), .out_ready(m_ready), .out_item(m_data)
    );

endmodule
